@@ design/unit_sphere_point_sampler_macros.svh @@
// ---------------------------------------------------------------------------
// unit sphere point sampler assertion macros
// Shared concurrent check helpers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef UNIT_SPHERE_POINT_SAMPLER_MACROS_SVH
`define UNIT_SPHERE_POINT_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define USPS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define USPS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define USPS_ASSERT(label, cond, msg)
`define USPS_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

@@ design/usps_pkg.sv @@
// ---------------------------------------------------------------------------
// usps_pkg
// Shared constants, types and arithmetic helpers of the sphere sampler.
// ---------------------------------------------------------------------------
package usps_pkg;
  localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
  localparam logic signed [31:0] SIN_C3 = 32'sd693598668;
  localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
  localparam logic signed [31:0] SIN_C7 = 32'sd5026995;
  localparam logic signed [31:0] SIN_C9 = 32'sd172272;
  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

  // mode flag (vol) and angle quadrant carried beside the data
  typedef struct packed {
    logic vol;
    logic [1:0] quad;
  } usps_ctl_t;

  // product of a and b over 2^s, rounded half away from zero
  // operand magnitudes stay within 2^31, so one 32 x 32 multiply is enough
  function automatic logic signed [63:0] mul_rnd(input logic signed [32:0] a,
                                                 input logic signed [32:0] b,
                                                 input int unsigned s);
    logic neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] m;
    neg = a[32] ^ b[32];
    ma = a[32] ? 32'(-a) : 32'(a);
    mb = b[32] ? 32'(-b) : 32'(b);
    m = 64'(ma) * 64'(mb);
    m = (m + (64'd1 << (s - 1))) >> s;
    mul_rnd = neg ? -$signed(m) : $signed(m);
  endfunction

  // final rounding to q15 with saturation
  function automatic logic [15:0] to_q15(input logic signed [63:0] v31);
    logic signed [63:0] v;
    v = mul_rnd(33'(v31), 33'sd1, 16);
    if (v > 64'sd32767) v = 64'sd32767;
    if (v < -64'sd32768) v = -64'sd32768;
    to_q15 = v[15:0];
  endfunction
endpackage

@@ design/usps_sine.sv @@
// ---------------------------------------------------------------------------
// usps_sine
// Pipelined quarter-wave sine polynomial, one multiply per stage.
// ---------------------------------------------------------------------------
module usps_sine import usps_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  f,
  output logic signed [31:0]  s
);
  logic signed [31:0] f_r [0:4];
  logic signed [31:0] x2_r [0:3];
  logic signed [31:0] p_r [0:5];
  logic signed [63:0] p_last;

  // horner steps, each behind its own register
  always_ff @(posedge clk) begin
    if (en) begin
      f_r[0]  <= f;
      x2_r[0] <= 32'(mul_rnd(33'(f), 33'(f), 30));
      p_r[0]  <= SIN_C9;
      f_r[1]  <= f_r[0];
      x2_r[1] <= x2_r[0];
      p_r[1]  <= 32'(mul_rnd(33'(p_r[0]), 33'(x2_r[0]), 30) - 64'(SIN_C7));
      f_r[2]  <= f_r[1];
      x2_r[2] <= x2_r[1];
      p_r[2]  <= 32'(mul_rnd(33'(p_r[1]), 33'(x2_r[1]), 30) + 64'(SIN_C5));
      f_r[3]  <= f_r[2];
      x2_r[3] <= x2_r[2];
      p_r[3]  <= 32'(mul_rnd(33'(p_r[2]), 33'(x2_r[2]), 30) - 64'(SIN_C3));
      f_r[4]  <= f_r[3];
      p_r[4]  <= 32'(mul_rnd(33'(p_r[3]), 33'(x2_r[3]), 30) + 64'(SIN_C1));
      p_r[5]  <= 32'(mul_rnd(33'(p_r[4]), 33'(f_r[4]), 30));
    end
  end

  // clamp to [0, 1]
  always_comb begin
    p_last = 64'(p_r[5]);
    if (p_last < 0) s = '0;
    else if (p_last > 64'(Q30_ONE)) s = Q30_ONE;
    else s = p_r[5];
  end
endmodule

@@ design/usps_roots.sv @@
// ---------------------------------------------------------------------------
// usps_roots
// Pipelined square root of 1 - z^2 and cube root of the radius sample.
// ---------------------------------------------------------------------------
module usps_roots import usps_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  logic [31:0]  zmag,
  input  logic [31:0]  r32,
  output logic [31:0]  t,
  output logic [20:0]  c
);
  localparam int SQ_STEPS = 32;
  localparam int CB_STEPS = 21;

  logic [63:0] sv_r [0:SQ_STEPS-1];
  logic [63:0] sres_r [0:SQ_STEPS];
  logic [63:0] cv_r [0:CB_STEPS-1];
  logic [63:0] csq_r [0:CB_STEPS-1];
  logic [63:0] ccu_r [0:CB_STEPS-1];
  logic [20:0] cres_r [0:CB_STEPS];
  logic [63:0] zsq;

  assign zsq = 64'(zmag) * 64'(zmag);

  // entry registers of both roots
  always_ff @(posedge clk) begin
    if (en) begin
      sv_r[0]   <= (64'd1 << 62) - zsq;
      sres_r[0] <= '0;
      cv_r[0]   <= {1'b0, r32, 31'd0};
      csq_r[0]  <= '0;
      ccu_r[0]  <= '0;
      cres_r[0] <= '0;
    end
  end

  // digit-by-digit square root, one result bit a stage
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    logic [63:0] bitv;
    logic [63:0] trial;
    logic        take;
    assign bitv  = 64'd1 << (62 - 2 * i);
    assign trial = sres_r[i] + bitv;
    assign take  = sv_r[i] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sres_r[i+1] <= take ? (sres_r[i] >> 1) + bitv : sres_r[i] >> 1;
      end
    end
    // remainder is only needed by the stages that follow
    if (i < SQ_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          sv_r[i+1] <= take ? sv_r[i] - trial : sv_r[i];
        end
      end
    end
  end

  // bitwise cube root, one result bit a stage
  // square and cube of the partial root are carried along, so a trial
  // cube is a sum of shifted terms: (r + 2^b)^3 = r^3 + 3r^2 2^b + 3r 4^b + 8^b
  for (genvar j = 0; j < CB_STEPS; j++) begin : g_cb
    localparam int B = CB_STEPS - 1 - j;
    logic [63:0] rw;
    logic [63:0] cube_try;
    logic        take;
    assign rw       = 64'(cres_r[j]);
    assign cube_try = ccu_r[j] + (csq_r[j] << B) + (csq_r[j] << (B + 1)) +
                      (rw << (2 * B)) + (rw << (2 * B + 1)) + (64'd1 << (3 * B));
    assign take     = cube_try <= cv_r[j];
    always_ff @(posedge clk) begin
      if (en) begin
        cres_r[j+1] <= take ? (cres_r[j] | (21'd1 << B)) : cres_r[j];
      end
    end
    if (j < CB_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          cv_r[j+1]  <= cv_r[j];
          csq_r[j+1] <= take ? csq_r[j] + (rw << (B + 1)) + (64'd1 << (2 * B))
                             : csq_r[j];
          ccu_r[j+1] <= take ? cube_try : ccu_r[j];
        end
      end
    end
  end

  assign t = sres_r[SQ_STEPS][31:0];

  // delay cube root to match the square root depth
  logic [20:0] cdl_r [0:SQ_STEPS-CB_STEPS-1];
  always_ff @(posedge clk) begin
    if (en) begin
      cdl_r[0] <= cres_r[CB_STEPS];
      for (int k = 1; k < SQ_STEPS - CB_STEPS; k++) cdl_r[k] <= cdl_r[k-1];
    end
  end
  assign c = cdl_r[SQ_STEPS-CB_STEPS-1];
endmodule

@@ design/unit_sphere_point_sampler.sv @@
// ---------------------------------------------------------------------------
// unit_sphere_point_sampler
// Uniform point on or inside the unit sphere from three uniform samples.
// ---------------------------------------------------------------------------
// Usage: present a request on in_* with in_valid; it is taken at a clock edge
// where in_valid is high and in_stall is low. One point leaves on out_pos_*
// with out_valid and is taken when out_stall is low.
// Throughput: one request per cycle while in_stall is low. Through an unstalled
// pipe, a request taken at a clock edge passes the entry register, then 32 square
// root stages, the two output multiplies and the output register, after which
// its point can be taken.
// The whole pipe advances together; when out_stall is high and the output
// register holds a point, the pipe freezes and in_stall is raised, so no
// request is lost or repeated. A free slot in the output register lets the
// pipe move even under stall.
// Reset clears the valid bits only; data registers are not reset.
// ---------------------------------------------------------------------------
`include "unit_sphere_point_sampler_macros.svh"
module unit_sphere_point_sampler import usps_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_opcode,
  input  logic [SAMPLE_BITS-1:0] in_u_angle,
  input  logic signed [SAMPLE_BITS-1:0] in_u_height,
  input  logic [SAMPLE_BITS-1:0] in_u_radius,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     out_pos_x,
  output logic signed [15:0]     out_pos_y,
  output logic signed [15:0]     out_pos_z
);
  localparam int ROOT_LAT = 32;
  localparam int PIPE = ROOT_LAT + 3;

  logic en;
  logic [PIPE-1:0] vld_r;
  logic [PIPE-1:0] vld_nxt;
  logic out_valid_r;
  logic [31:0] ang;
  logic [31:0] h32;
  logic [31:0] r32;
  logic [31:0] zmag;
  logic signed [31:0] f0;
  logic signed [31:0] g0;
  logic signed [31:0] sf;
  logic signed [31:0] sg;
  logic [31:0] t;
  logic [20:0] c;

  // widen samples to 32 fraction bits
  assign ang  = 32'(in_u_angle) << (32 - SAMPLE_BITS);
  assign h32  = 32'(in_u_height) << (32 - SAMPLE_BITS);
  assign r32  = 32'(in_u_radius) << (32 - SAMPLE_BITS);
  assign zmag = h32[31] ? 32'(-h32) : h32;
  assign f0   = {2'b00, ang[29:0]};
  assign g0   = Q30_ONE - f0;

  // pipe advances when the output slot is free or being taken
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  usps_sine u_sf (.clk(clk), .en(en), .f(f0), .s(sf));
  usps_sine u_sg (.clk(clk), .en(en), .f(g0), .s(sg));
  usps_roots u_rt (.clk(clk), .en(en), .zmag(zmag), .r32(r32), .t(t), .c(c));

  // side data delay line
  usps_ctl_t ctl_r [0:ROOT_LAT];
  logic signed [31:0] z_r [0:ROOT_LAT];
  logic signed [31:0] sf_d_r [0:ROOT_LAT-6];
  logic signed [31:0] sg_d_r [0:ROOT_LAT-6];
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= '{vol: in_opcode, quad: ang[31:30]};
      z_r[0]   <= $signed(h32);
      for (int k = 1; k <= ROOT_LAT; k++) begin
        ctl_r[k] <= ctl_r[k-1];
        z_r[k]   <= z_r[k-1];
      end
      sf_d_r[0] <= sf;
      sg_d_r[0] <= sg;
      for (int k = 1; k <= ROOT_LAT - 6; k++) begin
        sf_d_r[k] <= sf_d_r[k-1];
        sg_d_r[k] <= sg_d_r[k-1];
      end
    end
  end

  // quadrant mapping
  logic signed [31:0] sn;
  logic signed [31:0] cs;
  logic signed [31:0] sfa;
  logic signed [31:0] sga;
  assign sfa = sf_d_r[ROOT_LAT-6];
  assign sga = sg_d_r[ROOT_LAT-6];
  always_comb begin
    case (ctl_r[ROOT_LAT].quad)
      2'd0: begin sn = sfa;  cs = sga;  end
      2'd1: begin sn = sga;  cs = -sfa; end
      2'd2: begin sn = -sfa; cs = -sga; end
      default: begin sn = -sga; cs = sfa; end
    endcase
  end

  // x, y from t and the rotation
  logic signed [63:0] x_r;
  logic signed [63:0] y_r;
  logic signed [31:0] zz_r;
  logic [20:0] c_r;
  logic vol_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= mul_rnd(33'(t), 33'(cs), 30);
      y_r   <= mul_rnd(33'(t), 33'(sn), 30);
      zz_r  <= z_r[ROOT_LAT];
      c_r   <= c;
      vol_r <= ctl_r[ROOT_LAT].vol;
    end
  end

  // radius scaling
  logic signed [63:0] xs_r;
  logic signed [63:0] ys_r;
  logic signed [63:0] zs_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xs_r <= vol_r ? mul_rnd(33'(x_r), 33'(c_r), 21) : x_r;
      ys_r <= vol_r ? mul_rnd(33'(y_r), 33'(c_r), 21) : y_r;
      zs_r <= vol_r ? mul_rnd(33'(zz_r), 33'(c_r), 21) : 64'(zz_r);
    end
  end

  // output register
  logic signed [15:0] ox_r;
  logic signed [15:0] oy_r;
  logic signed [15:0] oz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= to_q15(xs_r);
      oy_r <= to_q15(ys_r);
      oz_r <= to_q15(zs_r);
    end
  end

  // valid bits travel with the data
  always_comb begin
    vld_nxt = {vld_r[PIPE-2:0], in_valid};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[PIPE-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = ox_r;
  assign out_pos_y = oy_r;
  assign out_pos_z = oz_r;

  `USPS_ASSERT_NEXT(a_hold, out_valid_r && out_stall, out_valid_r && $stable(ox_r), "held point changed")
  `USPS_ASSERT(a_stall, in_stall == (out_valid_r && out_stall), "stall mismatch")
  `USPS_ASSERT_NEXT(a_frz, in_stall, $stable(vld_r), "pipe moved while stalled")
endmodule
